// File: hdl/dkt_pkg.sv
// Shared constants and helpers for the sorted date key table.
package dkt_pkg;

    // Table geometry.
    localparam int MAX_ENTRIES = 512;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;

    // Request action codes.
    localparam logic [2:0] ACT_FIND   = 3'd0;
    localparam logic [2:0] ACT_ENSURE = 3'd1;
    localparam logic [2:0] ACT_PRUNE  = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // A key is valid when every BCD digit is 9 or less.
    function automatic logic key_valid(input logic [KEY_W-1:0] k);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < KEY_W / 4; d++) begin
            if (k[4*d +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: hdl/dkt_ram.sv
// Key store: one write port, one read port with registered read data.
module dkt_ram import dkt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [MAX_ENTRIES];
    logic [KEY_W-1:0] r_rdata;

    // Write when enabled and read every cycle; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sorted_date_key_table_core.sv
// Top level of the sorted date key table: request sequencer around the key store.
//
//  Channel   Signals                                         Direction
//  request   start, busy, i_action, i_date_key, i_slot       in (busy out)
//  result    o_done, o_status, o_position, o_key_out,        out
//            o_inserted, o_entry_count
//
// A request is taken when start is high and busy is low; its result shows
// for one cycle with o_done. Find runs at most floor(log2(n))+1 search steps
// for n held keys and none for an empty table; each step is one key store
// read and one compare. Ensure of a new key at slot p first moves the upper
// keys up one slot, one per cycle through the single write port. Prune
// makes one read and at most one compacting write per key.
// Reset is synchronous and empties the table; the key store itself is not
// cleared. The receiver cannot stall results.
module sorted_date_key_table_core import dkt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_action,
    input  logic [KEY_W-1:0] i_date_key,
    input  logic [IDX_W-1:0] i_slot,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [IDX_W-1:0] o_position,
    output logic [KEY_W-1:0] o_key_out,
    output logic             o_inserted,
    output logic [CNT_W-1:0] o_entry_count
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SRCH  = 8'b0000_0100,
        S_SCMP  = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_INS   = 8'b0010_0000,
        S_PRUNE = 8'b0100_0000,
        S_RDW   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_action, n_action;
    logic [KEY_W-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic             r_hit, n_hit;
    logic [CNT_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_p, n_p;
    logic             r_wv, n_wv;
    logic [IDX_W-1:0] r_wa, n_wa;
    logic [CNT_W-1:0] r_keep, n_keep;
    logic [CNT_W-1:0] r_i, n_i;
    logic             r_pv, n_pv;
    logic             r_done, n_done;
    logic [2:0]       r_status, n_status;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [KEY_W-1:0] r_kout, n_kout;
    logic             r_ins, n_ins;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [KEY_W-1:0] mem_rdata;

    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_mid;
    logic [CNT_W-1:0] w_cur_dec;
    logic [CNT_W-1:0] v_keep_nx;
    logic             v_found;

    dkt_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Search midpoint and shift source index.
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[CNT_W:1];
    assign w_cur_dec = CNT_W'(r_cur - 1'b1);

    // Sequencer next state, key store access and result values.
    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_key     = r_key;
        n_slot    = r_slot;
        n_count   = r_count;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_hit     = r_hit;
        n_cur     = r_cur;
        n_p       = r_p;
        n_wv      = r_wv;
        n_wa      = r_wa;
        n_keep    = r_keep;
        n_i       = r_i;
        n_pv      = r_pv;
        n_done    = 1'b0;
        n_status  = r_status;
        n_pos     = r_pos;
        n_kout    = r_kout;
        n_ins     = r_ins;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        v_keep_nx = r_keep;
        v_found   = r_hit && (r_lo < r_count);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state  = S_DISP;
                    n_action = i_action;
                    n_key    = i_date_key;
                    n_slot   = i_slot;
                end
            end
            S_DISP: begin
                // Clear the result and the working registers, then branch.
                n_lo     = '0;
                n_hi     = r_count;
                n_hit    = 1'b0;
                n_keep   = '0;
                n_i      = '0;
                n_pv     = 1'b0;
                n_wv     = 1'b0;
                n_status = ST_OK;
                n_pos    = '0;
                n_kout   = '0;
                n_ins    = 1'b0;
                unique case (r_action)
                    ACT_FIND, ACT_ENSURE: begin
                        if (!key_valid(r_key)) begin
                            n_status = ST_INVALID;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end
                    ACT_PRUNE: begin
                        if (!key_valid(r_key)) begin
                            n_status = ST_INVALID;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_PRUNE;
                        end
                    end
                    ACT_READ: begin
                        if ({1'b0, r_slot} >= r_count) begin
                            n_status = ST_RANGE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            mem_raddr = r_slot;
                            n_state   = S_RDW;
                        end
                    end
                    ACT_CLEAR: begin
                        n_count = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    // Fetch the middle key of the open range.
                    mem_raddr = w_mid[IDX_W-1:0];
                    n_state   = S_SCMP;
                end else if (r_action == ACT_FIND) begin
                    n_status = v_found ? ST_OK : ST_NOT_FOUND;
                    n_pos    = v_found ? r_lo[IDX_W-1:0] : '0;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (v_found) begin
                    n_pos   = r_lo[IDX_W-1:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                    n_status = ST_FULL;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_p     = r_lo[IDX_W-1:0];
                    n_cur   = r_count;
                    n_wv    = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_SCMP: begin
                // Narrow the range; remember whether the upper bound matches.
                if (mem_rdata < r_key) begin
                    n_lo = CNT_W'(w_mid + 1'b1);
                end else begin
                    n_hi  = w_mid;
                    n_hit = (mem_rdata == r_key);
                end
                n_state = S_SRCH;
            end
            S_SHIFT: begin
                // Read one slot down, write it one slot up in the next cycle.
                mem_we    = r_wv;
                mem_waddr = r_wa;
                mem_wdata = mem_rdata;
                if (r_cur > {1'b0, r_p}) begin
                    mem_raddr = w_cur_dec[IDX_W-1:0];
                    n_wa      = r_cur[IDX_W-1:0];
                    n_wv      = 1'b1;
                    n_cur     = w_cur_dec;
                end else begin
                    n_wv    = 1'b0;
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_p;
                mem_wdata = r_key;
                n_count   = CNT_W'(r_count + 1'b1);
                n_pos     = r_p;
                n_ins     = 1'b1;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_PRUNE: begin
                // Keep keys at or above the cutoff, packed from slot zero.
                if (r_pv && (mem_rdata >= r_key)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_keep[IDX_W-1:0];
                    mem_wdata = mem_rdata;
                    v_keep_nx = CNT_W'(r_keep + 1'b1);
                end
                n_keep = v_keep_nx;
                if (r_i < r_count) begin
                    mem_raddr = r_i[IDX_W-1:0];
                    n_i       = CNT_W'(r_i + 1'b1);
                    n_pv      = 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_count = v_keep_nx;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RDW: begin
                n_pos   = r_slot;
                n_kout  = mem_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_key    <= n_key;
        r_slot   <= n_slot;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_hit    <= n_hit;
        r_cur    <= n_cur;
        r_p      <= n_p;
        r_wv     <= n_wv;
        r_wa     <= n_wa;
        r_keep   <= n_keep;
        r_i      <= n_i;
        r_pv     <= n_pv;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_kout   <= n_kout;
        r_ins    <= n_ins;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_position    = r_pos;
    assign o_key_out     = r_kout;
    assign o_inserted    = r_ins;
    assign o_entry_count = r_count;

    // A result comes out only as the sequencer returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    // Every accepted request makes the sequencer busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the sequencer");

    // The table never holds more keys than it has slots.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // An insertion always reports success and grows the table.
    a_ins_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inserted) |-> (o_status == ST_OK && o_entry_count != '0))
        else $error("insertion with bad status or empty table");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the sorted date key table core.
`timescale 1ns / 1ps

module tb import dkt_pkg::*; ();

    // Spare action codes that the block treats as no operation.
    localparam logic [2:0] ACT_NOP5 = 3'd5;
    localparam logic [2:0] ACT_NOP6 = 3'd6;
    localparam logic [2:0] ACT_NOP7 = 3'd7;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 600;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] position;
        logic [KEY_W-1:0] key_out;
        logic             inserted;
        logic [CNT_W-1:0] entry_count;
    } t_table_result;

    typedef struct {
        logic [2:0]       act;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] slot;
        bit               typed;
        t_table_result    res;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [2:0]       i_action = '0;
    logic [KEY_W-1:0] i_date_key = '0;
    logic [IDX_W-1:0] i_slot = '0;
    logic             o_done;
    logic [2:0]       o_status;
    logic [IDX_W-1:0] o_position;
    logic [KEY_W-1:0] o_key_out;
    logic             o_inserted;
    logic [CNT_W-1:0] o_entry_count;

    // Shadow copy of the table, kept in step with accepted requests.
    logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
    int               shadow_count = 0;

    t_table_result    pending_results [$];
    logic [KEY_W-1:0] recent_keys [$];
    t_stim_row        directed_rows [$];
    int               fail_count = 0;
    int               quiet_cycles = 0;
    int               burst_left = 0;

    sorted_date_key_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_date_key    (i_date_key),
        .i_slot        (i_slot),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_key_out     (o_key_out),
        .o_inserted    (o_inserted),
        .o_entry_count (o_entry_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // A date key is usable only when every BCD digit is 9 or less.
    function automatic bit digits_ok(input logic [KEY_W-1:0] k);
        for (int d = 0; d < KEY_W / 4; d++) begin
            if (k[4*d +: 4] > 4'd9) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [KEY_W-1:0] to_bcd(input int v);
        logic [KEY_W-1:0] k;
        for (int d = 0; d < KEY_W / 4; d++) begin
            k[4*d +: 4] = 4'(v % 10);
            v = v / 10;
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] random_bcd();
        logic [KEY_W-1:0] k;
        for (int d = 0; d < KEY_W / 4; d++) begin
            k[4*d +: 4] = 4'($urandom_range(0, 9));
        end
        return k;
    endfunction

    // Apply one request to the shadow table and return the result it gives.
    function automatic t_table_result apply_request(input logic [2:0] act,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [IDX_W-1:0] slot);
        t_table_result r;
        int lo, hi, mid, keep;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_FIND, ACT_ENSURE: begin
                if (!digits_ok(key)) begin
                    r.status = ST_INVALID;
                end else begin
                    // Binary search for the first key not below the request key.
                    lo = 0;
                    hi = shadow_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (shadow_keys[mid] < key) begin
                            lo = mid + 1;
                        end else begin
                            hi = mid;
                        end
                    end
                    if (lo < shadow_count && shadow_keys[lo] == key) begin
                        r.position = IDX_W'(lo);
                    end else if (act == ACT_FIND) begin
                        r.status = ST_NOT_FOUND;
                    end else if (shadow_count >= MAX_ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = shadow_count; i > lo; i--) begin
                            shadow_keys[i] = shadow_keys[i-1];
                        end
                        shadow_keys[lo] = key;
                        shadow_count++;
                        r.position = IDX_W'(lo);
                        r.inserted = 1'b1;
                    end
                end
            end
            ACT_PRUNE: begin
                if (!digits_ok(key)) begin
                    r.status = ST_INVALID;
                end else begin
                    keep = 0;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_keys[i] >= key) begin
                            shadow_keys[keep] = shadow_keys[i];
                            keep++;
                        end
                    end
                    shadow_count = keep;
                end
            end
            ACT_READ: begin
                if (int'(slot) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.position = slot;
                    r.key_out = shadow_keys[slot];
                end
            end
            ACT_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = CNT_W'(shadow_count);
        return r;
    endfunction

    // Issue one request after a random gap, and wait until the block takes it.
    task automatic send_request(input logic [2:0] act, input logic [KEY_W-1:0] key,
                                input logic [IDX_W-1:0] slot, input bit typed = 1'b0,
                                input t_table_result typed_res = '0);
        int gap;
        t_table_result predicted;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(8, 40);
            end
            gap = $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_action   <= act;
        i_date_key <= key;
        i_slot     <= slot;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = apply_request(act, key, slot);
        pending_results.push_back(typed ? typed_res : predicted);
        if (act == ACT_ENSURE && digits_ok(key)) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 128) begin
                void'(recent_keys.pop_front());
            end
        end
    endtask

    // Hold requests off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        logic [KEY_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 40 && recent_keys.size() > 0) begin
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else if (roll < 50 && recent_keys.size() > 0) begin
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else if (roll < 55) begin
            k = $urandom_range(0, 1) ? 32'h9999_9999 : 32'h0000_0000;
        end else if (roll < 92) begin
            k = random_bcd();
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] pick_cutoff();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70 && shadow_count > 0) begin
            return shadow_keys[$urandom_range(0, (shadow_count - 1) / 3)];
        end else if (roll < 90) begin
            return random_bcd();
        end
        return $urandom;
    endfunction

    // Random mix of all actions with keys biased toward ones already held.
    task automatic run_mixed(input int count);
        int roll;
        logic [IDX_W-1:0] rslot;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            rslot = IDX_W'($urandom_range(0, 511));
            if (roll < 30) begin
                send_request(ACT_FIND, pick_key(), rslot);
            end else if (roll < 65) begin
                send_request(ACT_ENSURE, pick_key(), rslot);
            end else if (roll < 68) begin
                send_request(ACT_PRUNE, pick_cutoff(), rslot);
            end else if (roll < 92) begin
                if ($urandom_range(0, 9) < 7) begin
                    rslot = IDX_W'($urandom_range(0, shadow_count));
                end
                send_request(ACT_READ, $urandom, rslot);
            end else if (roll < 94) begin
                send_request(ACT_CLEAR, $urandom, rslot);
            end else if (roll < 96) begin
                send_request(3'($urandom_range(ACT_NOP5, ACT_NOP7)), $urandom, rslot);
            end else begin
                send_request(3'($urandom_range(ACT_FIND, ACT_PRUNE)), $urandom, rslot);
            end
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end
        end
    endtask

    function automatic void add_row(input logic [2:0] act, input logic [KEY_W-1:0] key,
                                    input logic [IDX_W-1:0] slot, input int typed,
                                    input logic [2:0] st, input int pos,
                                    input logic [KEY_W-1:0] kout, input int ins,
                                    input int cnt);
        t_stim_row row;
        row.act   = act;
        row.key   = key;
        row.slot  = slot;
        row.typed = (typed != 0);
        row.res   = '{st, IDX_W'(pos), kout, 1'(ins), CNT_W'(cnt)};
        directed_rows.push_back(row);
    endfunction

    // Compare each result with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    fail_count++;
                end
                if (o_key_out !== want.key_out) begin
                    $error("key_out: expected %h, got %h", want.key_out, o_key_out);
                    fail_count++;
                end
                if (o_inserted !== want.inserted) begin
                    $error("inserted: expected %0d, got %0d", want.inserted, o_inserted);
                    fail_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int run_val, fill_base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: empty table, key extremes, bad digits, duplicates, prune edges.
        add_row(ACT_FIND,   32'h2024_0101, 9'd0,   1, ST_NOT_FOUND, 0, 0, 0, 0);
        add_row(ACT_READ,   32'h0000_0000, 9'd0,   1, ST_RANGE,     0, 0, 0, 0);
        add_row(ACT_ENSURE, 32'hFFFF_FFFF, 9'd511, 1, ST_INVALID,   0, 0, 0, 0);
        add_row(ACT_FIND,   32'h0000_000A, 9'd0,   1, ST_INVALID,   0, 0, 0, 0);
        add_row(ACT_ENSURE, 32'h2024_0315, 9'd0,   1, ST_OK,        0, 0, 1, 1);
        add_row(ACT_ENSURE, 32'h0000_0000, 9'd0,   1, ST_OK,        0, 0, 1, 2);
        add_row(ACT_ENSURE, 32'h9999_9999, 9'd0,   1, ST_OK,        2, 0, 1, 3);
        add_row(ACT_ENSURE, 32'h2024_0315, 9'd0,   1, ST_OK,        1, 0, 0, 3);
        add_row(ACT_FIND,   32'h2024_0315, 9'd0,   1, ST_OK,        1, 0, 0, 3);
        add_row(ACT_FIND,   32'h2024_0316, 9'd0,   1, ST_NOT_FOUND, 0, 0, 0, 3);
        add_row(ACT_READ,   32'h0000_0000, 9'd2,   1, ST_OK,        2, 32'h9999_9999, 0, 3);
        add_row(ACT_READ,   32'h0000_0000, 9'd3,   1, ST_RANGE,     0, 0, 0, 3);
        add_row(ACT_READ,   32'hFFFF_FFFF, 9'd511, 1, ST_RANGE,     0, 0, 0, 3);
        add_row(ACT_ENSURE, 32'h1999_1231, 9'd0,   0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_PRUNE,  32'hA000_0000, 9'd0,   1, ST_INVALID,   0, 0, 0, 4);
        add_row(ACT_PRUNE,  32'h2024_0315, 9'd0,   0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_NOP5,   32'h1234_5678, 9'd85,  0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_NOP6,   32'hFFFF_FFFF, 9'd170, 0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_NOP7,   32'h0000_0000, 9'd511, 0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_READ,   32'h0000_0000, 9'd0,   0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_PRUNE,  32'h0000_0000, 9'd0,   0, ST_OK,        0, 0, 0, 0);
        add_row(ACT_CLEAR,  32'h0000_0000, 9'd0,   1, ST_OK,        0, 0, 0, 0);
        add_row(ACT_READ,   32'h0000_0000, 9'd0,   1, ST_RANGE,     0, 0, 0, 0);
        add_row(ACT_PRUNE,  32'h9999_9999, 9'd0,   0, ST_OK,        0, 0, 0, 0);
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].act, directed_rows[i].key, directed_rows[i].slot,
                         directed_rows[i].typed, directed_rows[i].res);
        end

        // Random mix while the table stays fairly small.
        run_mixed(280);

        // Fill the table with ascending keys, then push against the full table.
        drain_results();
        send_request(ACT_CLEAR, $urandom, IDX_W'($urandom_range(0, 511)));
        fill_base = $urandom_range(1, 1000000);
        run_val = fill_base;
        while (shadow_count < MAX_ENTRIES) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(ACT_ENSURE, to_bcd(run_val), IDX_W'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
                send_request(ACT_READ, $urandom, IDX_W'($urandom_range(0, shadow_count)));
            end else begin
                run_val += $urandom_range(1, 97);
                send_request(ACT_ENSURE, to_bcd(run_val), IDX_W'($urandom));
            end
        end
        send_request(ACT_ENSURE, to_bcd(run_val + 5), IDX_W'($urandom));
        send_request(ACT_ENSURE, to_bcd(fill_base - 1), IDX_W'($urandom));
        send_request(ACT_ENSURE, shadow_keys[$urandom_range(0, MAX_ENTRIES - 1)],
                     IDX_W'($urandom));
        send_request(ACT_FIND, shadow_keys[MAX_ENTRIES - 1], IDX_W'($urandom));
        send_request(ACT_READ, $urandom, IDX_W'(MAX_ENTRIES - 1));
        for (int n = 0; n < 8; n++) begin
            send_request(ACT_FIND, pick_key(), IDX_W'($urandom));
            send_request(ACT_READ, $urandom, IDX_W'($urandom));
        end

        // Cut the full table back and keep mixing from there.
        send_request(ACT_PRUNE, shadow_keys[$urandom_range(100, 300)], IDX_W'($urandom));
        run_mixed(200);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
